// ----- rtl/bsso_pkg.sv -----
// ----------------------------------------------------------------------------
// bsso_pkg
// Shared types and constants of the Black-Scholes stencil operator core.
// ----------------------------------------------------------------------------
package bsso_pkg;

   localparam int MAX_GRID_POINTS = 4096;
   localparam int SEEN_W          = $clog2(MAX_GRID_POINTS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // arithmetic widths
   localparam int OP_W       = 64;   // multiplier operand
   localparam int PROD_W     = 128;  // exact product
   localparam int Q_W        = 48;   // clipped internal quantity
   localparam int SPC_W      = 34;   // grid spacing
   localparam int DIV_Q_BITS = 49;   // quotient bits of 2^48 / h
   localparam int DIV_CNT_W  = $clog2(DIV_Q_BITS);
   localparam int SH_W       = 6;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIFORM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACE = 3'd4;

   typedef struct packed {
      logic signed [31:0] grid_x;
      logic signed [31:0] point_value;
      logic               final_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] operator_value;
      logic               at_boundary;
      logic               sweep_done;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] coeff_diffusion;
      logic signed [31:0] coeff_drift;
      logic signed [31:0] coeff_discount;
      logic               uniform_mode;
      logic [30:0]        inverse_spacing;
   } cfg_type;

   // one work unit handed from front to back
   typedef struct packed {
      logic signed [31:0] xm;
      logic signed [31:0] x0;
      logic signed [31:0] xp;
      logic signed [31:0] vm;
      logic signed [31:0] v0;
      logic signed [31:0] vp;
      logic               lead_valid;
      logic               lead_bnd;
      logic               tail;
   } job_type;

endpackage

// ----- rtl/bsso_front.sv -----
// ----------------------------------------------------------------------------
// bsso_front
// Accepts grid points, keeps the three-point window and queues work units.
// ----------------------------------------------------------------------------
module bsso_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsso_pkg::req_type req_payload,
   output logic              job_valid,
   input  logic              job_pop,
   output bsso_pkg::job_type job_data
);
   import bsso_pkg::*;

   localparam logic [SEEN_W-1:0] LAST_SEEN = SEEN_W'(MAX_GRID_POINTS - 1);

   logic signed [31:0] win_x_ff [2];
   logic signed [31:0] win_x_in [2];
   logic signed [31:0] win_v_ff [2];
   logic signed [31:0] win_v_in [2];
   logic [SEEN_W-1:0]  seen_ff, seen_in;

   job_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   logic    accept, fin, push, pop;
   job_type job_new;

   assign req_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;
   assign fin       = req_payload.final_point || (seen_ff == LAST_SEEN);

   always_comb begin
      job_new.xm         = win_x_ff[0];
      job_new.x0         = win_x_ff[1];
      job_new.xp         = req_payload.grid_x;
      job_new.vm         = win_v_ff[0];
      job_new.v0         = win_v_ff[1];
      job_new.vp         = req_payload.point_value;
      job_new.lead_valid = (seen_ff != '0);
      job_new.lead_bnd   = (seen_ff == SEEN_W'(1));
      job_new.tail       = fin;
   end

   assign push = accept && (job_new.lead_valid || fin);
   assign pop  = job_pop && job_valid;

   always_comb begin
      win_x_in = win_x_ff;
      win_v_in = win_v_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (fin) begin
            win_x_in[0] = '0;
            win_x_in[1] = '0;
            win_v_in[0] = '0;
            win_v_in[1] = '0;
            seen_in     = '0;
         end else begin
            win_x_in[0] = win_x_ff[1];
            win_v_in[0] = win_v_ff[1];
            win_x_in[1] = req_payload.grid_x;
            win_v_in[1] = req_payload.point_value;
            seen_in     = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff[0] <= '0;
         win_x_ff[1] <= '0;
         win_v_ff[0] <= '0;
         win_v_ff[1] <= '0;
         seen_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         win_x_ff  <= win_x_in;
         win_v_ff  <= win_v_in;
         seen_ff   <= seen_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= job_new;
      end
   end

   assign job_valid = (cnt_ff != '0);
   assign job_data  = q_mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/bsso_mul.sv -----
// ----------------------------------------------------------------------------
// bsso_mul
// Multi-cycle signed multiply, floor shift and clip to 48 bits.
// ----------------------------------------------------------------------------
module bsso_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [bsso_pkg::OP_W-1:0]  op_a,
   input  logic signed [bsso_pkg::OP_W-1:0]  op_b,
   input  logic [bsso_pkg::SH_W-1:0]         shift,
   output logic                              done,
   output logic signed [bsso_pkg::Q_W-1:0]   result,
   output logic                              sat
);
   import bsso_pkg::*;

   localparam logic [2:0] CNT_NEG  = 3'd5;
   localparam logic [2:0] CNT_CLIP = 3'd6;

   logic [OP_W-1:0]   ua_ff, ub_ff;
   logic              neg_ff;
   logic [SH_W-1:0]   sh_ff;
   logic [2:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic [OP_W-1:0]   pp_ff, pp_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic signed [Q_W-1:0] res_ff, res_in;
   logic              sat_ff, sat_in;
   logic              done_ff, done_in;

   logic [1:0]        pj, aj;
   logic [31:0]       ha, hb;
   logic [PROD_W-1:0] pp_wide, pp_shift;
   logic signed [PROD_W-1:0] sp;
   logic              fits;

   // partial product select: low/high halves
   assign pj = cnt_ff[1:0];
   assign ha = pj[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign hb = pj[0] ? ub_ff[63:32] : ub_ff[31:0];

   // accumulate the partial product registered in the previous cycle
   assign aj      = 2'(cnt_ff - 3'd1);
   assign pp_wide = PROD_W'(pp_ff);
   always_comb begin
      case (aj)
         2'd0:    pp_shift = pp_wide;
         2'd1:    pp_shift = pp_wide << 32;
         2'd2:    pp_shift = pp_wide << 32;
         2'd3:    pp_shift = pp_wide << 64;
         default: pp_shift = pp_wide;
      endcase
   end

   assign sp   = $signed(acc_ff) >>> sh_ff;
   assign fits = (&sp[PROD_W-1:Q_W-1]) || !(|sp[PROD_W-1:Q_W-1]);

   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (run_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff <= 3'd3) begin
            pp_in = ha * hb;
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + pp_shift;
         end
         if (cnt_ff == CNT_NEG && neg_ff) begin
            acc_in = -acc_ff;
         end
         if (cnt_ff == CNT_CLIP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            sat_in  = !fits;
            if (fits) begin
               res_in = sp[Q_W-1:0];
            end else if (sp[PROD_W-1]) begin
               res_in = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
               res_in = {1'b0, {(Q_W-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
         ub_ff  <= op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);
         neg_ff <= op_a[OP_W-1] ^ op_b[OP_W-1];
         sh_ff  <= shift;
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      pp_ff  <= pp_in;
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
   assign sat    = sat_ff;

endmodule

// ----- rtl/bsso_div.sv -----
// ----------------------------------------------------------------------------
// bsso_div
// Radix-2 restoring reciprocal: 2^48 / h, truncated toward zero.
// ----------------------------------------------------------------------------
module bsso_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [bsso_pkg::SPC_W-1:0]  divisor,
   output logic                               done,
   output logic signed [bsso_pkg::OP_W-1:0]   quotient
);
   import bsso_pkg::*;

   logic [SPC_W-1:0]      den_ff;
   logic [SPC_W-1:0]      rem_ff, rem_in;
   logic [DIV_Q_BITS-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  bit_ff, bit_in;
   logic                  neg_ff;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [SPC_W:0] trial;
   logic           take;

   // dividend is a single one at the top bit
   assign trial = {rem_ff, (bit_ff == DIV_CNT_W'(DIV_Q_BITS - 1))};
   assign take  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (run_ff) begin
         rem_in = take ? SPC_W'(trial - {1'b0, den_ff}) : SPC_W'(trial);
         quo_in = {quo_ff[DIV_Q_BITS-2:0], take};
         bit_in = bit_ff - DIV_CNT_W'(1);
         if (bit_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= start ? 1'b1 : run_in;
         done_ff <= start ? 1'b0 : done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor[SPC_W-1] ? SPC_W'(-divisor) : SPC_W'(divisor);
         neg_ff <= divisor[SPC_W-1];
         rem_ff <= '0;
         quo_ff <= '0;
         bit_ff <= DIV_CNT_W'(DIV_Q_BITS - 1);
      end else begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         bit_ff <= bit_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(OP_W'(quo_ff)) : $signed(OP_W'(quo_ff));

endmodule

// ----- rtl/bsso_back.sv -----
// ----------------------------------------------------------------------------
// bsso_back
// Carries out queued work units: stencil sequencer and result register.
// ----------------------------------------------------------------------------
module bsso_back (
   input  logic              clock,
   input  logic              reset,
   input  bsso_pkg::cfg_type cfg,
   input  logic              job_valid,
   output logic              job_pop,
   input  bsso_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsso_pkg::rsp_type rsp_payload
);
   import bsso_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LEAD  = 4'd1;
   localparam logic [3:0] ST_SETUP = 4'd2;
   localparam logic [3:0] ST_CHECK = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_SUM   = 4'd6;
   localparam logic [3:0] ST_PUT   = 4'd7;
   localparam logic [3:0] ST_TAIL  = 4'd8;

   localparam logic [3:0] MS_U_D1 = 4'd0;
   localparam logic [3:0] MS_U_D2 = 4'd1;
   localparam logic [3:0] MS_GP   = 4'd2;
   localparam logic [3:0] MS_GM   = 4'd3;
   localparam logic [3:0] MS_D2   = 4'd4;
   localparam logic [3:0] MS_M1   = 4'd5;
   localparam logic [3:0] MS_M2   = 4'd6;
   localparam logic [3:0] MS_D1   = 4'd7;
   localparam logic [3:0] MS_T0   = 4'd8;
   localparam logic [3:0] MS_T1   = 4'd9;
   localparam logic [3:0] MS_T2   = 4'd10;

   localparam logic [1:0] DV_HM = 2'd0;
   localparam logic [1:0] DV_HP = 2'd1;
   localparam logic [1:0] DV_HS = 2'd2;

   localparam logic signed [49:0] RES_MAX = 50'sd2147483647;
   localparam logic signed [49:0] RES_MIN = -50'sd2147483648;

   logic [3:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] dv_ff, dv_in;
   logic       mul_go_ff, mul_go_in;
   logic       div_go_ff, div_go_in;
   job_type    job_ff;

   logic signed [SPC_W-1:0] hm_ff, hm_in, hp_ff, hp_in, hs_ff, hs_in;
   logic [61:0]             inv2_ff, inv2_in;
   logic signed [OP_W-1:0]  rm_ff, rm_in, rp_ff, rp_in, rs_ff, rs_in;
   logic signed [Q_W-1:0]   gp_ff, gp_in, gm_ff, gm_in, d1_ff, d1_in, d2_ff, d2_in;
   logic signed [Q_W-1:0]   m1_ff, m1_in, t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic                    sat_ff, sat_in;
   logic signed [31:0]      res_ff, res_in;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    slot_free, load;

   logic signed [OP_W-1:0] op_a, op_b, vm64, v064, vp64;
   logic [SH_W-1:0]        op_sh;
   logic                   mul_done, mul_sat;
   logic signed [Q_W-1:0]  mul_res;
   logic signed [SPC_W-1:0] div_den;
   logic                   div_done;
   logic signed [OP_W-1:0] div_q;
   logic signed [49:0]     sum;

   bsso_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_go_ff),
      .op_a   (op_a),
      .op_b   (op_b),
      .shift  (op_sh),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   bsso_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign vm64 = OP_W'(job_ff.vm);
   assign v064 = OP_W'(job_ff.v0);
   assign vp64 = OP_W'(job_ff.vp);

   always_comb begin
      op_a  = '0;
      op_b  = '0;
      op_sh = SH_W'(24);
      case (step_ff)
         MS_U_D1: begin
            op_a  = vp64 - vm64;
            op_b  = $signed(OP_W'(cfg.inverse_spacing));
            op_sh = SH_W'(17);
         end
         MS_U_D2: begin
            op_a  = vp64 - (v064 <<< 1) + vm64;
            op_b  = $signed(OP_W'(inv2_ff));
            op_sh = SH_W'(32);
         end
         MS_GP: begin
            op_a = vp64 - v064;
            op_b = rp_ff;
         end
         MS_GM: begin
            op_a = v064 - vm64;
            op_b = rm_ff;
         end
         MS_D2: begin
            op_a = (OP_W'(gp_ff) - OP_W'(gm_ff)) <<< 1;
            op_b = rs_ff;
         end
         MS_M1: begin
            op_a = OP_W'(hm_ff);
            op_b = OP_W'(gp_ff);
         end
         MS_M2: begin
            op_a = OP_W'(hp_ff);
            op_b = OP_W'(gm_ff);
         end
         MS_D1: begin
            op_a = OP_W'(m1_ff) + OP_W'(mul_res);
            op_b = rs_ff;
         end
         MS_T0: begin
            op_a = OP_W'(cfg.coeff_diffusion);
            op_b = OP_W'(d2_ff);
         end
         MS_T1: begin
            op_a = OP_W'(cfg.coeff_drift);
            op_b = OP_W'(d1_ff);
         end
         MS_T2: begin
            op_a = OP_W'(cfg.coeff_discount);
            op_b = v064;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      case (dv_ff)
         DV_HM:   div_den = hm_ff;
         DV_HP:   div_den = hp_ff;
         default: div_den = hs_ff;
      endcase
   end

   assign sum = 50'(t0_ff) + 50'(t1_ff) + 50'(t2_ff);

   assign slot_free = !out_valid_ff || rsp_ready;
   assign job_pop   = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      dv_in     = dv_ff;
      mul_go_in = 1'b0;
      div_go_in = 1'b0;
      hm_in     = hm_ff;
      hp_in     = hp_ff;
      hs_in     = hs_ff;
      inv2_in   = inv2_ff;
      rm_in     = rm_ff;
      rp_in     = rp_ff;
      rs_in     = rs_ff;
      gp_in     = gp_ff;
      gm_in     = gm_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      m1_in     = m1_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      sat_in    = sat_ff;
      res_in    = res_ff;
      load      = 1'b0;
      out_in    = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            if (!job_ff.lead_valid) begin
               state_in = ST_TAIL;
            end else if (job_ff.lead_bnd) begin
               if (slot_free) begin
                  load     = 1'b1;
                  out_in   = '{operator_value: '0, at_boundary: 1'b1,
                               sweep_done: 1'b0, saturated: 1'b0};
                  state_in = ST_TAIL;
               end
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            hm_in    = SPC_W'(job_ff.x0) - SPC_W'(job_ff.xm);
            hp_in    = SPC_W'(job_ff.xp) - SPC_W'(job_ff.x0);
            hs_in    = SPC_W'(job_ff.xp) - SPC_W'(job_ff.xm);
            inv2_in  = cfg.inverse_spacing * cfg.inverse_spacing;
            sat_in   = 1'b0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cfg.uniform_mode) begin
               step_in   = MS_U_D1;
               mul_go_in = 1'b1;
               state_in  = ST_MUL;
            end else if (hm_ff == '0 || hp_ff == '0 || hs_ff == '0) begin
               // degenerate spacing
               res_in   = '0;
               sat_in   = 1'b1;
               state_in = ST_PUT;
            end else begin
               dv_in     = DV_HM;
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               case (dv_ff)
                  DV_HM:   rm_in = div_q;
                  DV_HP:   rp_in = div_q;
                  default: rs_in = div_q;
               endcase
               if (dv_ff == DV_HS) begin
                  step_in   = MS_GP;
                  mul_go_in = 1'b1;
                  state_in  = ST_MUL;
               end else begin
                  dv_in     = dv_ff + 2'd1;
                  div_go_in = 1'b1;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               sat_in    = sat_ff | mul_sat;
               mul_go_in = 1'b1;
               case (step_ff)
                  MS_U_D1: begin
                     d1_in   = mul_res;
                     step_in = MS_U_D2;
                  end
                  MS_U_D2: begin
                     d2_in   = mul_res;
                     step_in = MS_T0;
                  end
                  MS_GP: begin
                     gp_in   = mul_res;
                     step_in = MS_GM;
                  end
                  MS_GM: begin
                     gm_in   = mul_res;
                     step_in = MS_D2;
                  end
                  MS_D2: begin
                     d2_in   = mul_res;
                     step_in = MS_M1;
                  end
                  MS_M1: begin
                     m1_in   = mul_res;
                     step_in = MS_M2;
                  end
                  MS_M2: begin
                     // second product feeds the d1 operand straight from the unit
                     step_in   = MS_D1;
                     mul_go_in = 1'b1;
                  end
                  MS_D1: begin
                     d1_in   = mul_res;
                     step_in = MS_T0;
                  end
                  MS_T0: begin
                     t0_in   = mul_res;
                     step_in = MS_T1;
                  end
                  MS_T1: begin
                     t1_in   = mul_res;
                     step_in = MS_T2;
                  end
                  default: begin
                     t2_in     = mul_res;
                     mul_go_in = 1'b0;
                     state_in  = ST_SUM;
                  end
               endcase
            end
         end
         ST_SUM: begin
            if (sum > RES_MAX) begin
               res_in = 32'sh7fffffff;
               sat_in = 1'b1;
            end else if (sum < RES_MIN) begin
               res_in = 32'sh80000000;
               sat_in = 1'b1;
            end else begin
               res_in = sum[31:0];
            end
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (slot_free) begin
               load     = 1'b1;
               out_in   = '{operator_value: res_ff, at_boundary: 1'b0,
                            sweep_done: 1'b0, saturated: sat_ff};
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (!job_ff.tail) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               load     = 1'b1;
               out_in   = '{operator_value: '0, at_boundary: 1'b1,
                            sweep_done: 1'b1, saturated: 1'b0};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
      end
      step_ff <= step_in;
      dv_ff   <= dv_in;
      hm_ff   <= hm_in;
      hp_ff   <= hp_in;
      hs_ff   <= hs_in;
      inv2_ff <= inv2_in;
      rm_ff   <= rm_in;
      rp_ff   <= rp_in;
      rs_ff   <= rs_in;
      gp_ff   <= gp_in;
      gm_ff   <= gm_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      m1_ff   <= m1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      sat_ff  <= sat_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ----- rtl/black_scholes_stencil_operator_core.sv -----
// ----------------------------------------------------------------------------
// black_scholes_stencil_operator_core
// Streaming three-point Black-Scholes operator in log-price form.
// ----------------------------------------------------------------------------
// Grid points enter on req_ and the operator result of each point leaves on
// rsp_ one point late; the final point of a sweep yields two results. The
// front end queues up to two work units, so it keeps accepting while the
// back end computes. The back end's shared multi-cycle multiplier and its
// bit-serial reciprocal divider set the pace: an interior point takes five
// products in uniform mode and three reciprocals and nine products in
// non-uniform mode; a work unit that only carries boundary results uses
// neither unit and waits only on a result stall. The user must write the
// registers through csr_ only while the block is idle; the block itself
// does not enforce this.
module black_scholes_stencil_operator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bsso_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bsso_pkg::rsp_type                rsp_payload,
   input  logic                             csr_write_en,
   input  logic [bsso_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);
   import bsso_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    job_valid, job_pop;
   job_type job_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DIFFUSION: cfg_in.coeff_diffusion = csr_wdata;
            CSR_DRIFT:     cfg_in.coeff_drift     = csr_wdata;
            CSR_DISCOUNT:  cfg_in.coeff_discount  = csr_wdata;
            CSR_UNIFORM:   cfg_in.uniform_mode    = csr_wdata[0];
            CSR_INV_SPACE: cfg_in.inverse_spacing = csr_wdata[30:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsso_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (job_valid),
      .job_pop     (job_pop),
      .job_data    (job_data)
   );

   bsso_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_valid   (job_valid),
      .job_pop     (job_pop),
      .job_data    (job_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
